### hw/rtl/ps2_mouse_packet_tracker_defines.svh
// Assertion macros shared by the mouse packet tracker RTL.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define PS2MT_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define PS2MT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ps2mt_pkg.sv
// Shared types, constants and the clamp function for the mouse packet tracker.
// No dependencies; every other RTL module imports this package.
`default_nettype none

package ps2mt_pkg;

    localparam int unsigned PosW   = 16;
    localparam int unsigned BtnW   = 3;
    localparam int unsigned CfgIdxW = 2;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_X_LIMIT = 2'd0,
        CFG_Y_LIMIT = 2'd1
    } cfg_index_t;

    localparam logic [PosW-1:0] XLimitReset = 16'd1023;
    localparam logic [PosW-1:0] YLimitReset = 16'd767;

    // Header byte bit positions
    localparam int unsigned HdrSyncBit = 3;
    localparam int unsigned HdrXSignBit = 4;
    localparam int unsigned HdrYSignBit = 5;

    typedef struct packed {
        logic [PosW-1:0] x_limit;
        logic [PosW-1:0] y_limit;
    } limits_t;

    // One completed packet, handed from the byte tracker to the cursor unit
    typedef struct packed {
        logic            valid;
        logic [BtnW-1:0] buttons;
        logic            x_neg;
        logic            y_neg;
        logic [7:0]      x_low;
        logic [7:0]      y_low;
    } packet_t;

    // Add a 9-bit signed delta to a position and saturate to 0..limit
    function automatic logic [PosW-1:0] clamp_move(
        input logic [PosW-1:0] pos,
        input logic            neg,
        input logic [7:0]      low,
        input logic [PosW-1:0] limit
    );
        logic [PosW+1:0] delta;
        logic [PosW+1:0] sum;
        logic [PosW-1:0] res;
        delta = {{(PosW+2-8){neg}}, low};
        sum   = {2'b00, pos} + delta;
        if (sum[PosW+1]) begin
            res = '0;
        end else if (sum[PosW:0] > {1'b0, limit}) begin
            res = limit;
        end else begin
            res = sum[PosW-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ps2mt_cfg_regs.sv
// Configuration registers holding the x and y clamp limits.
// Depends on ps2mt_pkg.
`default_nettype none

module ps2mt_cfg_regs
    import ps2mt_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [PosW-1:0]    cfg_data,
    output limits_t                 limits
);

    logic [PosW-1:0] x_limit_reg;
    logic [PosW-1:0] y_limit_reg;

    assign cfg_ready = 1'b1;

    // Write the addressed limit; drop writes to unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_limit_reg <= XLimitReset;
            y_limit_reg <= YLimitReset;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_X_LIMIT: x_limit_reg <= cfg_data;
                CFG_Y_LIMIT: y_limit_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign limits.x_limit = x_limit_reg;
    assign limits.y_limit = y_limit_reg;

endmodule

`default_nettype wire

### hw/rtl/ps2mt_byte_tracker.sv
// Input word register and packet phase tracker; assembles 3-byte packets.
// Depends on ps2mt_pkg and the assertion macro header.
`default_nettype none

`include "ps2_mouse_packet_tracker_defines.svh"

module ps2mt_byte_tracker
    import ps2mt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic       out_free,
    output packet_t         pkt
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_XBYTE  = 3'b010,
        PH_YBYTE  = 3'b100
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic            in_valid_reg, in_valid_next;
    logic [7:0]      byte_reg;
    logic [BtnW-1:0] buttons_reg;
    logic            x_neg_reg;
    logic            y_neg_reg;
    logic [7:0]      x_low_reg;
    logic            advance;

    // Only the last byte of a packet needs room in the result register
    assign advance = in_valid_reg && ((phase_reg != PH_YBYTE) || out_free);
    assign s_ready = !in_valid_reg || advance;

    // Hold the input word until it is consumed
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    // Advance the packet phase; drop headers without the sync bit
    always_comb begin
        phase_next = phase_reg;
        if (advance) begin
            case (phase_reg)
                PH_HEADER: phase_next = byte_reg[HdrSyncBit] ? PH_XBYTE : PH_HEADER;
                PH_XBYTE:  phase_next = PH_YBYTE;
                PH_YBYTE:  phase_next = PH_HEADER;
                default:   phase_next = PH_HEADER;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            buttons_reg <= '0;
            x_neg_reg   <= 1'b0;
            y_neg_reg   <= 1'b0;
            x_low_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            if (advance && (phase_reg == PH_HEADER) && byte_reg[HdrSyncBit]) begin
                buttons_reg <= byte_reg[BtnW-1:0];
                x_neg_reg   <= byte_reg[HdrXSignBit];
                y_neg_reg   <= byte_reg[HdrYSignBit];
            end
            if (advance && (phase_reg == PH_XBYTE)) begin
                x_low_reg <= byte_reg;
            end
        end
    end

    // Hand the completed packet to the cursor unit
    assign pkt.valid   = advance && (phase_reg == PH_YBYTE);
    assign pkt.buttons = buttons_reg;
    assign pkt.x_neg   = x_neg_reg;
    assign pkt.y_neg   = y_neg_reg;
    assign pkt.x_low   = x_low_reg;
    assign pkt.y_low   = byte_reg;

    `PS2MT_ASSERT_NOW(a_pkt_needs_room, !pkt.valid || out_free, "packet issued while result register busy")
    `PS2MT_ASSERT_NEXT(a_pkt_resets_phase, pkt.valid, phase_reg == PH_HEADER, "phase did not return to header after packet")
    `PS2MT_ASSERT_NEXT(a_hold_word, in_valid_reg && !advance, in_valid_reg && $stable(byte_reg), "stalled input word lost")

endmodule

`default_nettype wire

### hw/rtl/ps2mt_cursor_unit.sv
// Cursor position registers with saturating update and the result register.
// Depends on ps2mt_pkg and the assertion macro header.
`default_nettype none

`include "ps2_mouse_packet_tracker_defines.svh"

module ps2mt_cursor_unit
    import ps2mt_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire packet_t pkt,
    input  wire limits_t limits,
    output logic        out_free,
    output logic        m_valid,
    input  wire logic   m_ready,
    output logic [PosW-1:0] m_pos_x,
    output logic [PosW-1:0] m_pos_y,
    output logic [BtnW-1:0] m_buttons
);

    logic [PosW-1:0] cursor_x_reg;
    logic [PosW-1:0] cursor_y_reg;
    logic [BtnW-1:0] buttons_reg;
    logic            out_valid_reg;
    logic [PosW-1:0] cursor_x_next;
    logic [PosW-1:0] cursor_y_next;

    assign out_free = !out_valid_reg || m_ready;

    // Move and saturate both axes
    assign cursor_x_next = clamp_move(cursor_x_reg, pkt.x_neg, pkt.x_low, limits.x_limit);
    assign cursor_y_next = clamp_move(cursor_y_reg, pkt.y_neg, pkt.y_low, limits.y_limit);

    // The cursor registers double as the result word; they only move when it is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            buttons_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else if (pkt.valid) begin
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            buttons_reg   <= pkt.buttons;
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_pos_x   = cursor_x_reg;
    assign m_pos_y   = cursor_y_reg;
    assign m_buttons = buttons_reg;

    `PS2MT_ASSERT_NEXT(a_pkt_gives_word, pkt.valid, out_valid_reg, "completed packet produced no result word")
    `PS2MT_ASSERT_NEXT(a_cursor_held, !pkt.valid, $stable(cursor_x_reg) && $stable(cursor_y_reg), "cursor moved without a packet")
    `PS2MT_ASSERT_NEXT(a_word_held, m_valid && !m_ready, m_valid && $stable(m_buttons), "word dropped")

endmodule

`default_nettype wire

### hw/rtl/ps2_mouse_packet_tracker.sv
// Top level of the mouse packet tracker: byte tracker, cursor unit, limit registers.
// Depends on ps2mt_pkg, ps2mt_cfg_regs, ps2mt_byte_tracker, ps2mt_cursor_unit.
//
// Takes one received mouse byte per word on the s_ channel and emits one
// word on the m_ channel per completed 3-byte packet: the cursor position
// after adding the sign-extended deltas, saturated to 0..limit, and the
// button bits. A header byte without bit 3 set is dropped to resynchronize.
// The block accepts one byte every cycle unless stalled; each byte is held
// in the input register, and the result is registered in the cursor registers
// when the packet's last byte advances. Only the last byte of a packet waits,
// when the previous result word has not yet been taken. The x and y limits
// (indexes 0 and 1, reset 1023 and 767) are written on the cfg_ port, which
// is always ready; write them only while no packet result is outstanding.
`default_nettype none

module ps2_mouse_packet_tracker
    import ps2mt_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [PosW-1:0]         m_pos_x,
    output logic [PosW-1:0]         m_pos_y,
    output logic [BtnW-1:0]         m_buttons,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [PosW-1:0]    cfg_data
);

    limits_t limits;
    packet_t pkt;
    logic    out_free;

    // Clamp limits
    ps2mt_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    // Packet assembly
    ps2mt_byte_tracker u_byte_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .out_free  (out_free),
        .pkt       (pkt)
    );

    // Cursor update and result word
    ps2mt_cursor_unit u_cursor_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pkt       (pkt),
        .limits    (limits),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_pos_x   (m_pos_x),
        .m_pos_y   (m_pos_y),
        .m_buttons (m_buttons)
    );

endmodule

`default_nettype wire
